[design/lgrs_pkg.sv]
// ----------------------------------------------------------------------------
// lgrs_pkg
// shared constants and types for the life generation row stream block
// ----------------------------------------------------------------------------
package lgrs_pkg;

   // cells per row and config register width
   localparam int unsigned MaxWidth   = 64;
   localparam int unsigned WidthBits  = 7;
   localparam logic [WidthBits-1:0] WidthReset = WidthBits'(MaxWidth);

   // result queue
   localparam int unsigned QueueDepth = 3;
   localparam int unsigned CountBits  = $clog2(QueueDepth + 1);

   // row-level control seen by every cell
   typedef struct packed {
      logic take;      // input row transfer this cycle
      logic holding;   // a row is held from before
      logic last;      // incoming row is the bottom row
   } ctrl_type;

   // column bits handed to the neighboring cells
   typedef struct packed {
      logic upper;     // row above the held row
      logic middle;    // held row
      logic below;     // incoming row (masked)
   } nbr_type;

   // one queued result
   typedef struct packed {
      logic [MaxWidth-1:0] row;
      logic                last;
   } result_type;

endpackage

[design/lgrs_cell.sv]
// ----------------------------------------------------------------------------
// lgrs_cell
// one board column: holds its upper and middle cell, counts live neighbors
// ----------------------------------------------------------------------------
module lgrs_cell (
   input  logic              clock,
   input  logic              reset,
   input  lgrs_pkg::ctrl_type ctrl,
   input  logic              row_bit,     // incoming cell, already masked
   input  logic              mask_bit,    // column is inside the active width
   input  lgrs_pkg::nbr_type lo_nbr,      // column one below in index
   input  lgrs_pkg::nbr_type hi_nbr,      // column one above in index
   output lgrs_pkg::nbr_type own_nbr,
   output logic              held_bit,    // next generation of the held row
   output logic              new_bit      // next generation of the incoming row
);

   logic       upper_ff, upper_in;
   logic       middle_ff, middle_in;
   logic [3:0] held_count;
   logic [3:0] new_count;
   logic       prev_lo, prev_c, prev_hi;

   // hand own bits to the neighbors
   assign own_nbr = '{upper: upper_ff, middle: middle_ff, below: row_bit};

   // neighbor count of the held row, incoming row below it
   assign held_count = 4'(lo_nbr.upper) + 4'(upper_ff) + 4'(hi_nbr.upper)
                     + 4'(lo_nbr.middle) + 4'(hi_nbr.middle)
                     + 4'(lo_nbr.below) + 4'(row_bit) + 4'(hi_nbr.below);

   // row above the incoming row when it is the bottom row
   assign prev_lo = ctrl.holding & lo_nbr.middle;
   assign prev_c  = ctrl.holding & middle_ff;
   assign prev_hi = ctrl.holding & hi_nbr.middle;

   // neighbor count of the incoming row, dead row below it
   assign new_count = 4'(prev_lo) + 4'(prev_c) + 4'(prev_hi)
                    + 4'(lo_nbr.below) + 4'(hi_nbr.below);

   // birth on three, survival on two or three
   assign held_bit = mask_bit & ((held_count == 4'd3) | ((held_count == 4'd2) & middle_ff));
   assign new_bit  = mask_bit & ((new_count == 4'd3) | ((new_count == 4'd2) & row_bit));

   // shift the column down one row per transfer, clear after the bottom row
   always_comb begin
      upper_in  = upper_ff;
      middle_in = middle_ff;
      if (ctrl.take) begin
         if (ctrl.last) begin
            upper_in  = 1'b0;
            middle_in = 1'b0;
         end else begin
            upper_in  = prev_c;
            middle_in = row_bit;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upper_ff  <= 1'b0;
         middle_ff <= 1'b0;
      end else begin
         upper_ff  <= upper_in;
         middle_ff <= middle_in;
      end
   end

endmodule

[design/life_generation_row_stream.sv]
// latency: a result is offered the cycle after the transfer that causes it, queue empty
// a bottom row that follows a held row gives two results, the second queued behind the first
// throughput: one row per cycle while the result queue holds at most one row; as after a
// two-result transfer, the input stalls while the queue holds two or more rows
// reset clears the held rows and the queue count, and sets active_width to 64
// ----------------------------------------------------------------------------
// life_generation_row_stream
// one Game of Life generation over a row stream, dead border, one cell per column
// ----------------------------------------------------------------------------
module life_generation_row_stream (
   input  logic                            clock,
   input  logic                            reset,
   // configuration write
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [lgrs_pkg::WidthBits-1:0]  csr_data,     // active_width
   // input rows
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [lgrs_pkg::MaxWidth-1:0]   req_tdata,    // row_cells
   input  logic                            req_tlast,    // last_row
   // result rows
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [lgrs_pkg::MaxWidth-1:0]   rsp_tdata,    // next_row
   output logic                            rsp_tlast     // is_last
);

   logic [lgrs_pkg::WidthBits-1:0] active_width_ff;
   logic                           holding_ff, holding_in;
   logic [lgrs_pkg::CountBits-1:0] count_ff, count_in;
   logic [lgrs_pkg::CountBits-1:0] base;
   lgrs_pkg::result_type           queue_ff [lgrs_pkg::QueueDepth];
   lgrs_pkg::result_type           queue_in [lgrs_pkg::QueueDepth];
   lgrs_pkg::result_type           first_res, second_res;
   lgrs_pkg::ctrl_type             ctrl;
   lgrs_pkg::nbr_type              nbr [lgrs_pkg::MaxWidth];
   logic [lgrs_pkg::MaxWidth-1:0]  width_mask;
   logic [lgrs_pkg::MaxWidth-1:0]  row_masked;
   logic [lgrs_pkg::MaxWidth-1:0]  held_row;
   logic [lgrs_pkg::MaxWidth-1:0]  new_row;
   logic                           take, pop, push_held, push_new;

   // configuration register
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_width_ff <= lgrs_pkg::WidthReset;
      end else if (csr_valid && csr_ready) begin
         active_width_ff <= csr_data;
      end
   end

   // column mask, widths past the row saturate
   always_comb begin
      for (int c = 0; c < lgrs_pkg::MaxWidth; c++) begin
         width_mask[c] = (active_width_ff > lgrs_pkg::WidthBits'(c));
      end
   end

   assign row_masked = req_tdata & width_mask;

   // handshakes
   assign take       = req_tvalid & req_tready;
   assign pop        = rsp_tvalid & rsp_tready;
   assign req_tready = (count_ff <= lgrs_pkg::CountBits'(1));
   assign rsp_tvalid = (count_ff != '0);
   assign rsp_tdata  = queue_ff[0].row;
   assign rsp_tlast  = queue_ff[0].last;

   assign ctrl = '{take: take, holding: holding_ff, last: req_tlast};

   // chain of column cells, dead columns past both edges
   for (genvar c = 0; c < lgrs_pkg::MaxWidth; c++) begin : g_col
      lgrs_pkg::nbr_type lo_side, hi_side;
      if (c == 0) begin : g_lo_edge
         assign lo_side = '0;
      end else begin : g_lo_link
         assign lo_side = nbr[c-1];
      end
      if (c == lgrs_pkg::MaxWidth - 1) begin : g_hi_edge
         assign hi_side = '0;
      end else begin : g_hi_link
         assign hi_side = nbr[c+1];
      end
      lgrs_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctrl     (ctrl),
         .row_bit  (row_masked[c]),
         .mask_bit (width_mask[c]),
         .lo_nbr   (lo_side),
         .hi_nbr   (hi_side),
         .own_nbr  (nbr[c]),
         .held_bit (held_row[c]),
         .new_bit  (new_row[c])
      );
   end

   // results caused by this transfer
   assign push_held  = take & holding_ff;
   assign push_new   = take & req_tlast;
   assign first_res  = push_held ? lgrs_pkg::result_type'{row: held_row, last: 1'b0}
                                 : lgrs_pkg::result_type'{row: new_row, last: 1'b1};
   assign second_res = '{row: new_row, last: 1'b1};

   // result queue: shift out at the head, append after the survivors
   always_comb begin
      base = count_ff - lgrs_pkg::CountBits'(pop);
      for (int i = 0; i < lgrs_pkg::QueueDepth - 1; i++) begin
         queue_in[i] = pop ? queue_ff[i+1] : queue_ff[i];
      end
      queue_in[lgrs_pkg::QueueDepth-1] = queue_ff[lgrs_pkg::QueueDepth-1];
      for (int i = 0; i < lgrs_pkg::QueueDepth; i++) begin
         if ((push_held || push_new) && base == lgrs_pkg::CountBits'(i)) begin
            queue_in[i] = first_res;
         end
         if (push_held && push_new
             && lgrs_pkg::CountBits'(base + lgrs_pkg::CountBits'(1))
                == lgrs_pkg::CountBits'(i)) begin
            queue_in[i] = second_res;
         end
      end
      count_in = base + lgrs_pkg::CountBits'(push_held) + lgrs_pkg::CountBits'(push_new);
   end

   // held-row flag
   assign holding_in = take ? ~req_tlast : holding_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         holding_ff <= 1'b0;
      end else begin
         count_ff   <= count_in;
         holding_ff <= holding_in;
      end
   end

   // queue payload
   always_ff @(posedge clock) begin
      for (int i = 0; i < lgrs_pkg::QueueDepth; i++) begin
         queue_ff[i] <= queue_in[i];
      end
   end

endmodule

[design/lgrs_checker.sv]
// ----------------------------------------------------------------------------
// lgrs_checker
// port-level checks for the life generation row stream block
// ----------------------------------------------------------------------------
module lgrs_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_tvalid,
   input logic                          req_tready,
   input logic                          rsp_tvalid,
   input logic                          rsp_tready,
   input logic [lgrs_pkg::MaxWidth-1:0] rsp_tdata,
   input logic                          rsp_tlast
);

   // a pending result is held until its transfer
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped before transfer");

   // a stalled result keeps its payload
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled result changed");

   // no result right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result offered after reset");

   // a result only appears after an input transfer
   a_no_invent: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid && !(req_tvalid && req_tready) |=> !rsp_tvalid)
      else $error("result without input transfer");

endmodule

bind life_generation_row_stream lgrs_checker u_lgrs_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
